>>> design/lcm_acc_pkg.sv
// Shared types and constants for the running LCM accumulator.
`timescale 1ns / 1ps
`default_nettype none

package lcm_acc_pkg;

    localparam int ACC_W  = 64;
    localparam int VAL_W  = 32;
    localparam int PROD_W = ACC_W + VAL_W;

    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [ACC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
        logic [ACC_W-1:0] remainder;
    } div_res_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] mcand;
        logic [VAL_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_res_t;

endpackage

`default_nettype wire

>>> design/lcm_acc_div.sv
// Restoring divider, one quotient bit per cycle, shared by GCD and final divide.
`timescale 1ns / 1ps
`default_nettype none

module lcm_acc_div (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  lcm_acc_pkg::div_req_t  req,
    output lcm_acc_pkg::div_res_t  res
);
    import lcm_acc_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] dq_reg, dq_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W:0]   shifted;
    logic             ge;

    always_comb begin
        shifted   = {rem_reg, dq_reg[ACC_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dq_next   = req.dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? ACC_W'(shifted - {1'b0, dvs_reg}) : shifted[ACC_W-1:0];
            dq_next  = {dq_reg[ACC_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ACC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (req.start) begin
            dvs_reg <= req.divisor;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = dq_reg;
    assign res.remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/lcm_acc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, 64 x 32 to 96 bits.
`timescale 1ns / 1ps
`default_nettype none

module lcm_acc_mul (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  lcm_acc_pkg::mul_req_t  req,
    output lcm_acc_pkg::mul_res_t  res
);
    import lcm_acc_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  mcand_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W:0]    sum;

    always_comb begin
        sum       = {1'b0, prod_reg[PROD_W-1:VAL_W]}
                    + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            prod_next = {{ACC_W{1'b0}}, req.mplier};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // add into the high half, then shift the whole product right
            prod_next = {sum, prod_reg[VAL_W-1:1]};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg <= prod_next;
        if (req.start) begin
            mcand_reg <= req.mcand;
        end
    end

    assign res.done    = done_reg;
    assign res.product = prod_reg;

endmodule

`default_nettype wire

>>> design/running_lcm_accumulator_top.sv
// Running LCM accumulator: sequencer around a shared divider and a serial multiplier.
// Sequence: each accepted item runs Euclid remainder steps on the shared divider, then
//   divides the running value by the GCD and multiplies by the item; an item with a zero
//   operand skips both units and goes straight to the output register (once it is free).
// A new item is taken only once the last result is loaded into the output register; the
//   remainders and the final divide use the bit-serial divider, the multiply the shift-add unit.
// Reset: aresetn low clears the running LCM to 1, the overflow flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module running_lcm_accumulator_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] value
    input  wire         s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [63:0] lcm_out
    output logic        m_tuser    // [0] overflow
);
    import lcm_acc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [ACC_W-1:0] a_reg, a_next;
    logic [ACC_W-1:0] b_reg, b_next;
    logic             div_start_reg, div_start_next;
    logic             mul_start_reg, mul_start_next;
    logic             out_valid_reg, out_valid_next;
    logic [ACC_W-1:0] out_lcm_reg;
    logic             out_ovf_reg;
    logic             in_acc;
    logic             load_out;
    logic [ACC_W-1:0] acc_eff;

    div_req_t div_req;
    div_res_t div_res;
    mul_req_t mul_req;
    mul_res_t mul_res;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign acc_eff  = s_tuser ? ACC_ONE : acc_reg;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = (state_reg == S_DIV) ? acc_reg : a_reg;
    assign div_req.divisor  = b_reg;

    assign mul_req.start  = mul_start_reg;
    assign mul_req.mcand  = div_res.quotient;
    assign mul_req.mplier = val_reg;

    lcm_acc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    lcm_acc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .res     (mul_res)
    );

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        val_next       = val_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        div_start_next = 1'b0;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    val_next = s_tdata;
                    ovf_next = s_tuser ? 1'b0 : ovf_reg;
                    a_next   = acc_eff;
                    b_next   = {{(ACC_W-VAL_W){1'b0}}, s_tdata};
                    if (acc_eff == '0 || s_tdata == '0) begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        acc_next       = acc_eff;
                        div_start_next = 1'b1;
                        state_next     = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (div_res.done) begin
                    div_start_next = 1'b1;
                    if (div_res.remainder == '0) begin
                        // b holds the GCD: divide the running value by it
                        state_next = S_DIV;
                    end else begin
                        a_next = b_reg;
                        b_next = div_res.remainder;
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_res.done) begin
                    acc_next = mul_res.product[ACC_W-1:0];
                    if (mul_res.product[PROD_W-1:ACC_W] != '0) begin
                        ovf_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_reg       <= ACC_ONE;
            ovf_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            div_start_reg <= div_start_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
        end
        val_reg <= val_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        if (load_out) begin
            out_lcm_reg <= acc_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_lcm_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GCD || state_reg == S_DIV) |-> (b_reg != '0))
        else $error("divider running with zero divisor");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovf_reg && !(in_acc && s_tuser)) |=> ovf_reg)
        else $error("overflow flag dropped without restart");

    a_zero_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg == '0 && !(in_acc && s_tuser)) |=> (acc_reg == '0))
        else $error("zero running value left zero without restart");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!div_res.done && !mul_res.done))
        else $error("arithmetic unit finished while sequencer idle");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the running LCM accumulator.
`timescale 1ns / 1ps

module tb_top;
    import lcm_acc_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 3300;
    localparam int unsigned CYCLE_LIMIT = 25_000_000;

    typedef struct packed {
        logic [ACC_W-1:0] lcm;
        logic             ovf;
    } lcm_result_t;

    // Tracks the running LCM and holds the results still owed by the block.
    class lcm_scoreboard;
        logic [ACC_W-1:0] run_lcm;
        logic             ovf_sticky;
        lcm_result_t      expected_lcm_q[$];
        int n_items, n_restarts, n_zeros, n_checked, n_ovf, n_errors;

        function new();
            run_lcm    = ACC_ONE;
            ovf_sticky = 1'b0;
        endfunction

        function logic [ACC_W-1:0] gcd64(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
            logic [ACC_W-1:0] r;
            while (b != '0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        function void fold_value(logic [VAL_W-1:0] v, logic rs);
            logic [ACC_W-1:0]  g;
            logic [ACC_W-1:0]  q;
            logic [PROD_W-1:0] prod;
            lcm_result_t       r;
            n_items++;
            if (rs) begin
                run_lcm    = ACC_ONE;
                ovf_sticky = 1'b0;
                n_restarts++;
            end
            if (v == '0)
                n_zeros++;
            if (run_lcm == '0 || v == '0) begin
                run_lcm = '0;
            end else begin
                g    = gcd64(run_lcm, ACC_W'(v));
                q    = run_lcm / g;
                prod = PROD_W'(q) * PROD_W'(v);
                // any bit above the accumulator width means the exact LCM did not fit
                if (prod[PROD_W-1:ACC_W] != '0)
                    ovf_sticky = 1'b1;
                run_lcm = prod[ACC_W-1:0];
            end
            r.lcm = run_lcm;
            r.ovf = ovf_sticky;
            expected_lcm_q.push_back(r);
        endfunction

        function void check_result(logic [ACC_W-1:0] lcm, logic ovf);
            lcm_result_t e;
            if (expected_lcm_q.size() == 0) begin
                $display("%0t: result with no item pending, lcm_out %h overflow %b",
                         $time, lcm, ovf);
                n_errors++;
                return;
            end
            e = expected_lcm_q.pop_front();
            n_checked++;
            if (ovf)
                n_ovf++;
            if (lcm !== e.lcm) begin
                $display("%0t: lcm_out expected %h, got %h", $time, e.lcm, lcm);
                n_errors++;
            end
            if (ovf !== e.ovf) begin
                $display("%0t: overflow expected %b, got %b", $time, e.ovf, ovf);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_lcm_q.size();
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [VAL_W-1:0]  s_tdata  = '0;   // [31:0] value
    logic              s_tuser  = 1'b0; // [0] restart
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ACC_W-1:0]  m_tdata;         // [63:0] lcm_out
    logic              m_tuser;         // [0] overflow

    lcm_scoreboard lcm_sb = new();

    int          n_accepted = 0;
    int          burst_left = 0;
    int          rx_left    = 0;
    int          rx_pick;
    logic        rx_ready   = 1'b0;
    int unsigned cycle_cnt  = 0;

    running_lcm_accumulator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, lcm_sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                lcm_sb.fold_value(s_tdata, s_tuser);
                n_accepted++;
            end
            if (m_tvalid && m_tready)
                lcm_sb.check_result(m_tdata, m_tuser);
        end
    end

    // Receiver: ready and stall runs of random length in random order, with long open stretches.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_pick = $urandom_range(0, 9);
            if (rx_pick < 4) begin
                rx_ready = 1'b1;
                rx_left  = $urandom_range(1, 30);
            end else if (rx_pick < 7) begin
                rx_ready = 1'b0;
                rx_left  = $urandom_range(1, 6);
            end else if (rx_pick == 7) begin
                rx_ready = 1'b0;
                rx_left  = $urandom_range(20, 120);
            end else begin
                rx_ready = 1'b1;
                rx_left  = $urandom_range(200, 600);
            end
        end
        rx_left--;
        m_tready <= rx_ready;
    end

    // Present one item and hold it until the block takes it; gaps fall between bursts.
    task automatic send_item(input logic [VAL_W-1:0] v, input logic rs);
        int target;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(40, 400)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        target = n_accepted + 1;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= rs;
        do @(negedge aclk); while (n_accepted < target);
    endtask

    // Hold the sender until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (lcm_sb.pending() != 0);
        burst_left = 0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value(int flavor);
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 39))
            0:       v = '0;
            1:       v = 32'd1;
            2:       v = 32'd1 << $urandom_range(0, 31);
            3:       v = ~VAL_W'($urandom_range(0, 15));
            default: begin
                case (flavor)
                    0:       v = $urandom_range(2, 64);
                    1:       v = $urandom_range(2, 4096);
                    2:       v = $urandom_range(2, 32'h00FF_FFFF);
                    default: v = $urandom();
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        int  sent;
        int  seq_len;
        int  flavor;
        bit  drained_mid;
        logic rs;

        sent        = 0;
        drained_mid = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // widest values from the reset state, then past 64 bits
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'hFFFF_FFFD, 1'b0);
        send_item(32'd1, 1'b0);
        // restart clears the sticky flag
        send_item(32'd12, 1'b1);
        send_item(32'd18, 1'b0);
        // zero value forces zero until the next restart
        send_item(32'd0, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd0, 1'b1);
        send_item(32'd7, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'd1, 1'b1);
        send_item(32'd1, 1'b0);
        // overflow followed by a zero: flag stays set while the value is zero
        send_item(32'hFFFF_FFFB, 1'b1);
        send_item(32'hFFFF_FFEF, 1'b0);
        send_item(32'hFFFF_FFF1, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd3, 1'b0);
        // alternating bit patterns
        send_item(32'hAAAA_AAAA, 1'b1);
        send_item(32'h5555_5555, 1'b0);
        // consecutive Fibonacci numbers drive the longest remainder chain
        send_item(32'd2971215073, 1'b1);
        send_item(32'd1836311903, 1'b0);
        wait_drained();

        // mostly restart-led sequences of random length and value range, with some noise
        while (sent < RANDOM_ITEMS) begin
            flavor  = $urandom_range(0, 3);
            seq_len = $urandom_range(1, 12);
            for (int k = 0; k < seq_len; k++) begin
                rs = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
                send_item(pick_value(flavor), rs);
                sent++;
            end
            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Folded %0d items (%0d restarts, %0d zero values) in %0d cycles.",
                 lcm_sb.n_items, lcm_sb.n_restarts, lcm_sb.n_zeros, cycle_cnt);
        $display("Checked %0d results, %0d of them with the overflow flag set.",
                 lcm_sb.n_checked, lcm_sb.n_ovf);
        if (lcm_sb.n_errors == 0 && lcm_sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
